[sv/lspq_pkg.sv]
// package for the linear scan priority queue: sizes, codes and the types
// shared by the cell chain and the top level; no dependencies
`default_nettype none

package lspq_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = 6;
    localparam int DATA_W  = 32;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 48;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    // best candidate travelling down the chain
    typedef struct packed {
        logic                      found;
        logic [IDX_W-1:0]          idx;
        logic signed [DATA_W-1:0]  prio;
        logic signed [DATA_W-1:0]  value;
    } cand_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                      wr;
        logic                      shift;
        logic [CNT_W-1:0]          count;
        logic [IDX_W-1:0]          best_idx;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  prio;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/lspq_cell.sv]
// one queue entry: stored value and priority plus one stage of the max scan
// depends on lspq_pkg
`default_nettype none

module lspq_cell (
    input  wire logic                             aclk,
    input  wire logic [lspq_pkg::IDX_W-1:0]       cell_idx,
    input  wire lspq_pkg::cell_ctrl_t             ctrl,
    input  wire logic signed [lspq_pkg::DATA_W-1:0] up_value,
    input  wire logic signed [lspq_pkg::DATA_W-1:0] up_prio,
    input  wire lspq_pkg::cand_t                  cand_in,
    output logic signed [lspq_pkg::DATA_W-1:0]    value_out,
    output logic signed [lspq_pkg::DATA_W-1:0]    prio_out,
    output lspq_pkg::cand_t                       cand_out
);
    import lspq_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic signed [DATA_W-1:0] prio_reg, prio_next;
    cand_t                    cand_reg, cand_next;
    logic                     occupied;
    logic                     take;

    assign occupied = {1'b0, cell_idx} < ctrl.count;

    always_comb begin
        // >= so that the lower (older) entry wins a tie as the scan moves down
        take = occupied &&
               (!cand_in.found || ($signed(prio_reg) >= $signed(cand_in.prio)));
        if (take) begin
            cand_next = '{found: 1'b1, idx: cell_idx, prio: prio_reg, value: value_reg};
        end else begin
            cand_next = cand_in;
        end
    end

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.wr && (cell_idx == ctrl.count[IDX_W-1:0])) begin
            value_next = ctrl.value;
            prio_next  = ctrl.prio;
        end else if (ctrl.shift && (cell_idx >= ctrl.best_idx)) begin
            value_next = up_value;
            prio_next  = up_prio;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
        cand_reg  <= cand_next;
    end

    assign value_out = value_reg;
    assign prio_out  = prio_reg;
    assign cand_out  = cand_reg;

endmodule

`default_nettype wire

[sv/linear_scan_priority_queue_core.sv]
// top level of the linear scan priority queue: sequencer, result stage and
// the chain of entry cells; depends on lspq_pkg and lspq_cell
`default_nettype none

// Bounded priority queue of up to 32 (value, priority) entries kept in arrival
// order in a chain of cells. An add, a clear or an unused op code is done in
// the cycle it is accepted. An extract sends a best-so-far candidate down the
// whole cell chain, one cell per cycle, then shifts the later entries down.
// No new item is taken until the last result has moved on to the output
// register. An extract on an empty queue finishes at once. The highest signed
// priority wins, the oldest entry on ties. capacity (reset 32) is clamped to
// 32; write it only while idle.

module linear_scan_priority_queue_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // op[1:0], value[33:2], prio[65:34], zero pad
    input  wire logic [lspq_pkg::IN_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // out_value[31:0], status[33:32], count[39:34], is_full[40], is_empty[41], zero pad
    output logic [lspq_pkg::OUT_W-1:0]     m_tdata,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [lspq_pkg::CNT_W-1:0] cfg_data
);
    import lspq_pkg::*;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         scan_reg, scan_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         cap_reg;
    logic                     pend_valid_reg, pend_valid_next;
    logic [OUT_W-1:0]         pend_data_reg, pend_data_next;
    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         m_tdata_reg;

    logic                     accept;
    logic [1:0]               in_op;
    logic signed [DATA_W-1:0] in_value;
    logic signed [DATA_W-1:0] in_prio;
    logic [CNT_W-1:0]         cap_eff;
    logic                     res_load;
    logic [DATA_W-1:0]        res_value;
    status_t                  res_status;
    logic                     out_free;

    cell_ctrl_t               ctrl;
    cand_t                    cand_w  [DEPTH+1];
    logic signed [DATA_W-1:0] value_w [DEPTH+1];
    logic signed [DATA_W-1:0] prio_w  [DEPTH+1];

    assign in_op    = s_tdata[1:0];
    assign in_value = s_tdata[33:2];
    assign in_prio  = s_tdata[65:34];

    assign s_tready  = (state_reg == S_IDLE) && !pend_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cap_eff   = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && (in_op == OP_EXTRACT) && (count_reg != '0)) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_reg == '0) begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        scan_next     = scan_reg;
        ctrl.wr       = 1'b0;
        ctrl.shift    = 1'b0;
        ctrl.count    = count_reg;
        ctrl.best_idx = cand_w[0].idx;
        ctrl.value    = in_value;
        ctrl.prio     = in_prio;
        count_next    = count_reg;
        res_load      = 1'b0;
        res_value     = '0;
        res_status    = STAT_OK;
        case (state_reg)
            S_IDLE: begin
                scan_next = IDX_W'(DEPTH - 1);
                if (accept) begin
                    case (in_op)
                        OP_ADD: begin
                            res_load = 1'b1;
                            if (count_reg >= cap_eff) begin
                                res_status = STAT_FULL;
                            end else begin
                                ctrl.wr    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                res_load   = 1'b1;
                                res_status = STAT_EMPTY;
                            end
                        end
                        OP_CLEAR: begin
                            res_load   = 1'b1;
                            count_next = '0;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                scan_next = scan_reg - 1'b1;
            end
            S_SHIFT: begin
                ctrl.shift = 1'b1;
                res_load   = 1'b1;
                res_value  = cand_w[0].value;
                count_next = count_reg - 1'b1;
            end
            default: begin
                scan_next = scan_reg;
            end
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (res_load) begin
            pend_valid_next = 1'b1;
            pend_data_next  = {6'b0, (count_next == '0), (count_next >= cap_eff),
                               count_next, res_status, res_value};
        end else if (pend_valid_reg && out_free) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            count_reg      <= '0;
            cap_reg        <= CNT_W'(32);
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (out_free) begin
                m_tvalid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_data_reg <= pend_data_next;
        if (out_free && pend_valid_reg) begin
            m_tdata_reg <= pend_data_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the scan enters at the top of the chain with no candidate
    assign cand_w[DEPTH]  = '{found: 1'b0, idx: '0, prio: '0, value: '0};
    assign value_w[DEPTH] = '0;
    assign prio_w[DEPTH]  = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        lspq_cell u_cell (
            .aclk      (aclk),
            .cell_idx  (IDX_W'(k)),
            .ctrl      (ctrl),
            .up_value  (value_w[k+1]),
            .up_prio   (prio_w[k+1]),
            .cand_in   (cand_w[k+1]),
            .value_out (value_w[k]),
            .prio_out  (prio_w[k]),
            .cand_out  (cand_w[k])
        );
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("scan running on an empty queue");

    a_shift_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("extract did not remove exactly one entry");

    a_shift_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |-> (cand_w[0].found && ({1'b0, cand_w[0].idx} < count_reg)))
        else $error("scan ended without a valid entry");

endmodule

`default_nettype wire
